// ===== design/dpr_pkg.sv =====
// dpr_pkg: shared types, codes and helpers of the debounced pair reporter.
// No dependencies.
package dpr_pkg;

    localparam int SENSOR_COUNT = 2;
    localparam int QUEUE_DEPTH  = 2;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BURST_CNT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BURST_GAP = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEARTBEAT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_STUCK     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_SETTLE    = 3'd5;

    localparam logic [1:0] CODE_BOTH_PRESENT = 2'd0;
    localparam logic [1:0] CODE_ONE_MISSING  = 2'd1;
    localparam logic [1:0] CODE_BOTH_MISSING = 2'd2;

    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_RESET  = 1'b1;

    typedef struct packed {
        logic [15:0] debounce_ticks;
        logic [7:0]  burst_count;
        logic [15:0] burst_gap_ticks;
        logic [31:0] heartbeat_ticks;
        logic [31:0] stuck_ticks;
        logic [31:0] settle_ticks;
    } cfg_t;

    // What one tick asks the back end to send.
    typedef struct packed {
        logic        ping;
        logic        rpt;
        logic        rst;
        logic        stable_a;
        logic        stable_b;
        logic [1:0]  code;
        logic        settling;
        logic [31:0] uptime;
    } plan_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] seq_number;
        logic        stable_a;
        logic        stable_b;
        logic [1:0]  combined_state;
        logic        boot_flag;
        logic        pong_flag;
        logic        settling_flag;
        logic [31:0] uptime;
        logic        last;
    } result_t;

    function automatic logic [1:0] combine(input logic [SENSOR_COUNT-1:0] lvl);
        logic [1:0] c;
        if (&lvl)
            c = CODE_BOTH_PRESENT;
        else if (|lvl)
            c = CODE_ONE_MISSING;
        else
            c = CODE_BOTH_MISSING;
        return c;
    endfunction

endpackage

// ===== design/debounced_pair_reporter.sv =====
// debounced_pair_reporter: top level, configuration registers and channel glue.
// Depends on dpr_pkg, dpr_tick_front, dpr_plan_queue, dpr_report_seq.
//
// Usage:
//   Input side is a queue write: drive the six tick fields with push high; the
//   tick is taken on a rising edge where full is low. One tick per cycle can
//   be taken while the plan queue has room.
//   Result side is a queue read: while empty is low the oldest result item sits
//   on the result ports; pop high at a rising edge takes it.
//   Each tick yields zero to three items (pong report, burst or heartbeat
//   report, reset request); the final one of a tick carries last.
//   A tick's first item passes the plan queue, the back end's plan register
//   and the output register. The back end loads a plan, then sends one item
//   per cycle while the output register is free; that plan load plus per-item
//   emission sets the sustained rate, and a new plan loads only after the last
//   item of the current one. A tick that causes no item is dropped at its load.
//   When the receiver stalls the output register holds, the back end stops,
//   the two-entry plan queue fills and then full rises; nothing is dropped.
//   Reset clears all control state: uptime 0, boot flag pending, sequence 0,
//   registers at their defaults. Configuration is written with cfg_write,
//   cfg_index and cfg_data while the block is idle; unknown indexes are ignored.
module debounced_pair_reporter
    import dpr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   push,
    output logic                   full,
    input  logic                   raw_sensor_a,
    input  logic                   raw_sensor_b,
    input  logic                   ping_request,
    input  logic                   reboot_request,
    input  logic                   send_done,
    input  logic                   send_ok,
    output logic                   empty,
    input  logic                   pop,
    output logic                   kind,
    output logic [15:0]            seq_number,
    output logic                   stable_a,
    output logic                   stable_b,
    output logic [1:0]             combined_state,
    output logic                   boot_flag,
    output logic                   pong_flag,
    output logic                   settling_flag,
    output logic [31:0]            uptime,
    output logic                   last
);

    cfg_t    cfg_reg;
    plan_t   front_plan, queue_plan;
    logic    accept, q_not_empty, q_rd;
    result_t res;

    // Configuration registers, masked to their widths.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks  <= 16'd500;
            cfg_reg.burst_count     <= 8'd3;
            cfg_reg.burst_gap_ticks <= 16'd50;
            cfg_reg.heartbeat_ticks <= 32'd1000;
            cfg_reg.stuck_ticks     <= 32'd30000;
            cfg_reg.settle_ticks    <= 32'd3000;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_DEBOUNCE:  cfg_reg.debounce_ticks  <= cfg_data[15:0];
                CFG_BURST_CNT: cfg_reg.burst_count     <= cfg_data[7:0];
                CFG_BURST_GAP: cfg_reg.burst_gap_ticks <= cfg_data[15:0];
                CFG_HEARTBEAT: cfg_reg.heartbeat_ticks <= cfg_data;
                CFG_STUCK:     cfg_reg.stuck_ticks     <= cfg_data;
                CFG_SETTLE:    cfg_reg.settle_ticks    <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign accept = push && !full;

    dpr_tick_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .raw_sensor_a   (raw_sensor_a),
        .raw_sensor_b   (raw_sensor_b),
        .ping_request   (ping_request),
        .reboot_request (reboot_request),
        .send_done      (send_done),
        .send_ok        (send_ok),
        .cfg            (cfg_reg),
        .plan           (front_plan)
    );

    dpr_plan_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (accept),
        .wr_data   (front_plan),
        .rd        (q_rd),
        .rd_data   (queue_plan),
        .full      (full),
        .not_empty (q_not_empty)
    );

    dpr_report_seq u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .plan_valid (q_not_empty),
        .plan       (queue_plan),
        .plan_pop   (q_rd),
        .result     (res),
        .empty      (empty),
        .pop        (pop)
    );

    assign kind           = res.kind;
    assign seq_number     = res.seq_number;
    assign stable_a       = res.stable_a;
    assign stable_b       = res.stable_b;
    assign combined_state = res.combined_state;
    assign boot_flag      = res.boot_flag;
    assign pong_flag      = res.pong_flag;
    assign settling_flag  = res.settling_flag;
    assign uptime         = res.uptime;
    assign last           = res.last;

    a_reset_item_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == KIND_RESET) |->
            (seq_number == 16'd0 && uptime == 32'd0 && !boot_flag && !pong_flag))
        else $error("reset request carries report fields");

endmodule

// ===== design/dpr_plan_queue.sv =====
// dpr_plan_queue: small register queue of tick plans between front and back.
// Depends on dpr_pkg.
module dpr_plan_queue
    import dpr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr,
    input  plan_t wr_data,
    input  logic  rd,
    output plan_t rd_data,
    output logic  full,
    output logic  not_empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    plan_t            mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr && !rd)
            count_next = count_reg + 1'b1;
        else if (rd && !wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !wr)
        else $error("plan queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !not_empty |-> !rd)
        else $error("plan queue read while empty");

endmodule

// ===== design/dpr_tick_front.sv =====
// dpr_tick_front: per-tick debounce, state classification and report scheduling.
// Depends on dpr_pkg; produces one plan per accepted tick.
module dpr_tick_front
    import dpr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  accept,
    input  logic  raw_sensor_a,
    input  logic  raw_sensor_b,
    input  logic  ping_request,
    input  logic  reboot_request,
    input  logic  send_done,
    input  logic  send_ok,
    input  cfg_t  cfg,
    output plan_t plan
);

    logic [31:0]             tick_reg, tick_next;
    logic [SENSOR_COUNT-1:0] latch_reg, latch_next;
    logic [SENSOR_COUNT-1:0] stable_reg, stable_next;
    logic [31:0]             ctime_reg [SENSOR_COUNT];
    logic [31:0]             ctime_next [SENSOR_COUNT];
    logic [1:0]              book_reg, book_next;
    logic                    started_reg;
    logic [7:0]              rem_reg, rem_next;
    logic [31:0]             nbt_reg, nbt_next;
    logic [31:0]             lrt_reg, lrt_next;
    logic [31:0]             lok_reg, lok_next;
    logic                    ever_ok_reg, ever_ok_next;

    logic [SENSOR_COUNT-1:0] raw;
    logic                    ok, sched, burst_due, hb_due, stuck_due;
    logic [7:0]              rem_eff;
    logic [31:0]             nbt_diff, lrt_diff, lok_diff, age;

    assign raw = {raw_sensor_b, raw_sensor_a};
    assign ok  = send_done && send_ok;

    always_comb
    begin
        latch_next  = latch_reg;
        stable_next = stable_reg;
        ctime_next  = ctime_reg;
        book_next   = book_reg;
        sched       = 1'b0;
        age         = '0;
        if (!started_reg)
        begin
            latch_next  = raw;
            stable_next = raw;
            for (int i = 0; i < SENSOR_COUNT; i++)
                ctime_next[i] = tick_reg;
            book_next = combine(raw);
            sched     = 1'b1;
        end
        else
        begin
            for (int i = 0; i < SENSOR_COUNT; i++)
            begin
                if (raw[i] != latch_reg[i])
                begin
                    latch_next[i] = raw[i];
                    ctime_next[i] = tick_reg;
                end
                age = tick_reg - ctime_next[i];
                if (age >= {16'd0, cfg.debounce_ticks})
                    stable_next[i] = latch_next[i];
            end
            if (combine(stable_next) != book_reg)
            begin
                book_next = combine(stable_next);
                sched     = 1'b1;
            end
        end
    end

    // A fresh schedule has next burst time = now, so it is due at once unless the burst count is zero.
    always_comb
    begin
        rem_eff   = sched ? cfg.burst_count : rem_reg;
        nbt_diff  = tick_reg - nbt_reg;
        lrt_diff  = tick_reg - lrt_reg;
        burst_due = sched ? (cfg.burst_count != '0) : ((rem_reg != '0) && !nbt_diff[31]);
        hb_due    = !burst_due &&
                    (ping_request ? (cfg.heartbeat_ticks == '0)
                                  : (lrt_diff >= cfg.heartbeat_ticks));
        rem_next  = rem_eff;
        nbt_next  = sched ? tick_reg : nbt_reg;
        if (!reboot_request && burst_due)
        begin
            rem_next = rem_eff - 1'b1;
            nbt_next = tick_reg + {16'd0, cfg.burst_gap_ticks};
        end
        lrt_next = (!reboot_request && (ping_request || burst_due || hb_due)) ?
                   tick_reg : lrt_reg;

        ever_ok_next = ever_ok_reg || ok;
        lok_next     = ok ? tick_reg : lok_reg;
        lok_diff     = tick_reg - lok_next;
        stuck_due    = ever_ok_next && (lok_diff >= cfg.stuck_ticks);
        tick_next    = tick_reg + 1'b1;
    end

    always_comb
    begin
        plan.ping     = !reboot_request && ping_request;
        plan.rpt      = !reboot_request && (burst_due || hb_due);
        plan.rst      = reboot_request || stuck_due;
        plan.stable_a = stable_next[0];
        plan.stable_b = stable_next[1];
        plan.code     = book_next;
        plan.settling = (tick_reg < cfg.settle_ticks);
        plan.uptime   = tick_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg    <= '0;
            latch_reg   <= '0;
            stable_reg  <= '0;
            for (int i = 0; i < SENSOR_COUNT; i++)
                ctime_reg[i] <= '0;
            book_reg    <= CODE_BOTH_MISSING;
            started_reg <= 1'b0;
            rem_reg     <= '0;
            nbt_reg     <= '0;
            lrt_reg     <= '0;
            lok_reg     <= '0;
            ever_ok_reg <= 1'b0;
        end
        else if (accept)
        begin
            tick_reg    <= tick_next;
            latch_reg   <= latch_next;
            stable_reg  <= stable_next;
            ctime_reg   <= ctime_next;
            book_reg    <= book_next;
            started_reg <= 1'b1;
            rem_reg     <= rem_next;
            nbt_reg     <= nbt_next;
            lrt_reg     <= lrt_next;
            lok_reg     <= lok_next;
            ever_ok_reg <= ever_ok_next;
        end
    end

    a_book_tracks_levels: assert property (@(posedge clk) disable iff (!rst_n)
        started_reg |-> (book_reg == combine(stable_reg)))
        else $error("booked state differs from stable levels");

endmodule

// ===== design/dpr_report_seq.sv =====
// dpr_report_seq: expands tick plans into result items, owns sequence and boot flag.
// Depends on dpr_pkg; feeds the single-entry output register.
module dpr_report_seq
    import dpr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    plan_valid,
    input  plan_t   plan,
    output logic    plan_pop,
    output result_t result,
    output logic    empty,
    input  logic    pop
);

    plan_t      cur_reg, cur_next;
    logic [2:0] pend_reg, pend_next;   // {reset, report, ping}
    logic       cur_valid_reg, cur_valid_next;
    result_t    out_reg, out_next;
    logic       out_valid_reg, out_valid_next;
    logic [15:0] seq_reg, seq_next;
    logic       boot_reg, boot_next;

    logic       out_free, load, emit, emit_last;
    logic [2:0] pend_after;
    result_t    item;

    assign out_free = !out_valid_reg || pop;
    assign load     = !cur_valid_reg && plan_valid;
    assign plan_pop = load;
    assign emit     = cur_valid_reg && out_free;
    assign empty    = !out_valid_reg;
    assign result   = out_reg;

    always_comb
    begin
        item       = '0;
        pend_after = pend_reg;
        seq_next   = seq_reg;
        boot_next  = boot_reg;
        if (pend_reg[0] || pend_reg[1])
        begin
            if (pend_reg[0])
                pend_after[0] = 1'b0;
            else
                pend_after[1] = 1'b0;
            item.kind           = KIND_REPORT;
            item.seq_number     = seq_reg + 1'b1;
            item.stable_a       = cur_reg.stable_a;
            item.stable_b       = cur_reg.stable_b;
            item.combined_state = cur_reg.code;
            item.boot_flag      = boot_reg;
            item.pong_flag      = pend_reg[0];
            item.settling_flag  = cur_reg.settling;
            item.uptime         = cur_reg.uptime;
            if (emit)
            begin
                seq_next  = seq_reg + 1'b1;
                boot_next = 1'b0;
            end
        end
        else
        begin
            pend_after[2] = 1'b0;
            item.kind     = KIND_RESET;
        end
        emit_last = (pend_after == '0);
        item.last = emit_last;
    end

    always_comb
    begin
        cur_next       = cur_reg;
        pend_next      = pend_reg;
        cur_valid_next = cur_valid_reg;
        if (load)
        begin
            cur_next       = plan;
            pend_next      = {plan.rst, plan.rpt, plan.ping};
            cur_valid_next = plan.rst || plan.rpt || plan.ping;
        end
        else if (emit)
        begin
            pend_next      = pend_after;
            cur_valid_next = !emit_last;
        end
        out_next       = emit ? item : out_reg;
        out_valid_next = emit ? 1'b1 : (pop ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            seq_reg       <= '0;
            boot_reg      <= 1'b1;
        end
        else
        begin
            pend_reg      <= pend_next;
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
            seq_reg       <= seq_next;
            boot_reg      <= boot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

    a_pending_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (pend_reg != '0))
        else $error("active plan with nothing left to send");

    a_last_retires: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && emit_last) |=> !cur_valid_reg)
        else $error("plan still active after its last item");

    a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && item.kind == KIND_REPORT) |=> (seq_reg == $past(seq_reg) + 16'd1))
        else $error("sequence number did not advance by one");

endmodule

// ===== sim/debounced_pair_reporter_test.sv =====
`timescale 1ns / 1ps
// debounced_pair_reporter_test: self-checking testbench for debounced_pair_reporter.
// Depends on dpr_pkg and the block's RTL; a built-in forecast of the report stream
// checks every result item field by field.
module debounced_pair_reporter_test;
    import dpr_pkg::*;

    localparam int RUN_LIMIT    = 200000; // cycles; slowest legal run is far below this
    localparam int DRAIN_CYCLES = 8;      // drain after the last owed item; lets a no-item tick settle
    localparam int RANDOM_TICKS = 50;     // per random phase
    localparam int PHASES       = 6;
    localparam int FIRST_TICKS  = 3;      // directed ticks run on the reset register values

    // Index with no register behind it; a write there must change nothing.
    localparam logic [CFG_INDEX_W-1:0] CFG_NONE = 3'd7;

    // One millisecond tick as the block sees it.
    typedef struct packed {
        logic a;
        logic b;
        logic ping;
        logic reboot;
        logic done;
        logic ok;
    } tick_t;

    typedef enum int {POP_FREE, POP_COIN, POP_CYCLE} pop_mode_t;

    // Directed ticks, bits {a, b, ping, reboot, done, ok}.
    localparam logic [5:0] DIRECTED [23] = '{
        6'b110000,  // first tick after reset: levels load, boot report
        6'b111000,  // ping
        6'b100011,  // first good send
        6'b110000,  // --- new register setting from here on
        6'b111000,  // ping
        6'b010011,  // a drops, send ok restarts the stuck timer
        6'b010000,  // a settles: one missing, burst starts
        6'b011000,  // ping on top of burst
        6'b000000,  // b drops too
        6'b001000,
        6'b000000,  // stuck timer has run out by now
        6'b101000,  // ping + burst/heartbeat + reset request: three items
        6'b101100,  // reboot beats ping: single reset request
        6'b100111,  // reboot with a good send
        6'b100010,  // send finished but failed
        6'b100001,  // ok without done counts for nothing
        6'b110000,
        6'b010000,  // one-tick glitch
        6'b110000,
        6'b110011,
        6'b000000,
        6'b110000,
        6'b111011
    };

    // ------------------------------------------------------------------
    // Forecast of the report stream: own copy of the registers and of the
    // debounce / burst / heartbeat / stuck-radio state, plus the queue of
    // result items still owed by the block.
    // ------------------------------------------------------------------
    class report_forecast;
        cfg_t        regs;
        logic [31:0] tick_now;
        logic [1:0]  raw_held;     // bit 0 sensor a, bit 1 sensor b
        logic [1:0]  stable_lvl;
        logic [31:0] changed_at [2];
        logic [1:0]  book;
        logic        started;
        logic        boot_pending;
        logic        ever_ok;
        logic [15:0] seq;
        logic [7:0]  burst_left;
        logic [31:0] burst_due;
        logic [31:0] last_report;
        logic [31:0] last_ok;
        result_t     owed [$];
        int          mismatches;
        int          reports_seen;
        int          resets_seen;

        function new();
            regs.debounce_ticks  = 16'd500;
            regs.burst_count     = 8'd3;
            regs.burst_gap_ticks = 16'd50;
            regs.heartbeat_ticks = 32'd1000;
            regs.stuck_ticks     = 32'd30000;
            regs.settle_ticks    = 32'd3000;
            tick_now      = '0;
            raw_held      = '0;
            stable_lvl    = '0;
            changed_at[0] = '0;
            changed_at[1] = '0;
            book          = CODE_BOTH_MISSING;
            started       = 1'b0;
            boot_pending  = 1'b1;
            ever_ok       = 1'b0;
            seq           = '0;
            burst_left    = '0;
            burst_due     = '0;
            last_report   = '0;
            last_ok       = '0;
            mismatches    = 0;
            reports_seen  = 0;
            resets_seen   = 0;
        endfunction

        // Narrow registers keep only their low bits.
        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_DEBOUNCE:  regs.debounce_ticks  = val[15:0];
                CFG_BURST_CNT: regs.burst_count     = val[7:0];
                CFG_BURST_GAP: regs.burst_gap_ticks = val[15:0];
                CFG_HEARTBEAT: regs.heartbeat_ticks = val;
                CFG_STUCK:     regs.stuck_ticks     = val;
                CFG_SETTLE:    regs.settle_ticks    = val;
                default: ;
            endcase
        endfunction

        function logic [1:0] level_code();
            case (stable_lvl)
                2'b11:   return CODE_BOTH_PRESENT;
                2'b00:   return CODE_BOTH_MISSING;
                default: return CODE_ONE_MISSING;
            endcase
        endfunction

        function result_t report(logic [31:0] now, logic pong);
            result_t r;
            seq              = seq + 16'd1;
            r                = '0;
            r.kind           = KIND_REPORT;
            r.seq_number     = seq;
            r.stable_a       = stable_lvl[0];
            r.stable_b       = stable_lvl[1];
            r.combined_state = book;
            r.boot_flag      = boot_pending;
            r.pong_flag      = pong;
            r.settling_flag  = (now < regs.settle_ticks);
            r.uptime         = now;
            boot_pending     = 1'b0;
            last_report      = now;
            return r;
        endfunction

        // Reset requests carry nothing but kind and last.
        function result_t reset_request();
            result_t r;
            r      = '0;
            r.kind = KIND_RESET;
            return r;
        endfunction

        // Called for every accepted tick; queues the items it owes.
        function void take_tick(tick_t t);
            logic [31:0] now;
            logic [31:0] span;
            logic [1:0]  raw;
            logic [1:0]  code;
            result_t     made [3];
            int          n;
            now = tick_now;
            raw = {t.b, t.a};
            n   = 0;
            if (t.done && t.ok) begin
                last_ok = now;
                ever_ok = 1'b1;
            end
            if (!started) begin
                raw_held      = raw;
                stable_lvl    = raw;
                changed_at[0] = now;
                changed_at[1] = now;
                started       = 1'b1;
                book          = level_code();
                burst_left    = regs.burst_count;
                burst_due     = now;
            end else begin
                for (int i = 0; i < 2; i++) begin
                    if (raw[i] != raw_held[i]) begin
                        raw_held[i]   = raw[i];
                        changed_at[i] = now;
                    end
                    span = now - changed_at[i];
                    if (span >= regs.debounce_ticks)
                        stable_lvl[i] = raw_held[i];
                end
                code = level_code();
                if (code != book) begin
                    book       = code;
                    burst_left = regs.burst_count;
                    burst_due  = now;
                end
            end

            if (t.reboot) begin
                made[n] = reset_request();
                n++;
            end else begin
                if (t.ping) begin
                    made[n] = report(now, 1'b1);
                    n++;
                end
                // burst slot is due when now is not before burst_due (signed compare)
                span = now - burst_due;
                if (burst_left != 0 && !span[31]) begin
                    burst_left = burst_left - 8'd1;
                    burst_due  = now + regs.burst_gap_ticks;
                    made[n]    = report(now, 1'b0);
                    n++;
                end else begin
                    span = now - last_report;
                    if (span >= regs.heartbeat_ticks) begin
                        made[n] = report(now, 1'b0);
                        n++;
                    end
                end
                span = now - last_ok;
                if (ever_ok && span >= regs.stuck_ticks) begin
                    made[n] = reset_request();
                    n++;
                end
            end
            if (n > 0)
                made[n-1].last = 1'b1;
            for (int k = 0; k < n; k++)
                owed.push_back(made[k]);
            tick_now = now + 32'd1;
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void match_item(result_t got);
            result_t want;
            if (owed.size() == 0) begin
                $error("unexpected result item: kind %0d seq %0d uptime %0d",
                       got.kind, got.seq_number, got.uptime);
                mismatches++;
                return;
            end
            want = owed.pop_front();
            if (want.kind == KIND_RESET)
                resets_seen++;
            else
                reports_seen++;
            check_field("kind",           want.kind,           got.kind);
            check_field("seq_number",     want.seq_number,     got.seq_number);
            check_field("stable_a",       want.stable_a,       got.stable_a);
            check_field("stable_b",       want.stable_b,       got.stable_b);
            check_field("combined_state", want.combined_state, got.combined_state);
            check_field("boot_flag",      want.boot_flag,      got.boot_flag);
            check_field("pong_flag",      want.pong_flag,      got.pong_flag);
            check_field("settling_flag",  want.settling_flag,  got.settling_flag);
            check_field("uptime",         want.uptime,         got.uptime);
            check_field("last",           want.last,           got.last);
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and block
    // ------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                   cfg_write      = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index      = '0;
    logic [CFG_DATA_W-1:0]  cfg_data       = '0;
    logic                   push           = 1'b0;
    logic                   raw_sensor_a   = 1'b0;
    logic                   raw_sensor_b   = 1'b0;
    logic                   ping_request   = 1'b0;
    logic                   reboot_request = 1'b0;
    logic                   send_done      = 1'b0;
    logic                   send_ok        = 1'b0;
    logic                   pop            = 1'b0;

    logic        full;
    logic        empty;
    logic        kind;
    logic [15:0] seq_number;
    logic        stable_a;
    logic        stable_b;
    logic [1:0]  combined_state;
    logic        boot_flag;
    logic        pong_flag;
    logic        settling_flag;
    logic [31:0] uptime;
    logic        last;

    always #6 clk = ~clk;

    debounced_pair_reporter u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .push           (push),
        .full           (full),
        .raw_sensor_a   (raw_sensor_a),
        .raw_sensor_b   (raw_sensor_b),
        .ping_request   (ping_request),
        .reboot_request (reboot_request),
        .send_done      (send_done),
        .send_ok        (send_ok),
        .empty          (empty),
        .pop            (pop),
        .kind           (kind),
        .seq_number     (seq_number),
        .stable_a       (stable_a),
        .stable_b       (stable_b),
        .combined_state (combined_state),
        .boot_flag      (boot_flag),
        .pong_flag      (pong_flag),
        .settling_flag  (settling_flag),
        .uptime         (uptime),
        .last           (last)
    );

    report_forecast forecast;

    int        ticks_sent    = 0;
    int        settings_done = 0;
    int        burst_run     = 0;   // ticks left before the sender may idle
    pop_mode_t pop_mode      = POP_FREE;
    int        pop_window    = 0;
    int        pop_phase     = 0;
    int        cycles        = 0;

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Presents a tick and holds it until the block takes it.
    task automatic send_tick(tick_t t);
        push <= 1'b1;
        {raw_sensor_a, raw_sensor_b, ping_request, reboot_request, send_done, send_ok} <= t;
        do @(posedge clk); while (full);
        forecast.take_tick(t);
        ticks_sent++;
    endtask

    // Bursts of back-to-back ticks, sometimes long, with a random idle gap between bursts.
    task automatic pace();
        if (burst_run > 0) begin
            burst_run--;
        end else begin
            push <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_run = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                    : $urandom_range(0, 6);
        end
    endtask

    // Hold off until every owed item has come back, then let the pipe settle.
    task automatic wait_idle();
        push <= 1'b0;
        while (forecast.owed.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        forecast.write_reg(idx, val);
    endtask

    // Writes all six registers; bits above a register's width carry junk,
    // and one write goes to an index with no register.
    task automatic write_setting(cfg_t c);
        write_reg(CFG_DEBOUNCE,  {16'($urandom()), c.debounce_ticks});
        write_reg(CFG_BURST_CNT, {24'($urandom()), c.burst_count});
        write_reg(CFG_BURST_GAP, {16'($urandom()), c.burst_gap_ticks});
        write_reg(CFG_HEARTBEAT, c.heartbeat_ticks);
        write_reg(CFG_STUCK,     c.stuck_ticks);
        write_reg(CFG_SETTLE,    c.settle_ticks);
        write_reg(CFG_NONE,      $urandom());
        cfg_write <= 1'b0;
        settings_done++;
    endtask

    // ------------------------------------------------------------------
    // Receiver side: pops on one of three patterns, redrawn at random per window:
    // free-running, random stalls, or a fixed 3-of-5 duty cycle.
    // Outputs are sampled as they stood before the edge.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && pop && !empty)
            forecast.match_item({kind, seq_number, stable_a, stable_b, combined_state,
                                 boot_flag, pong_flag, settling_flag, uptime, last});
        if (pop_window == 0) begin
            pop_mode   = pop_mode_t'($urandom_range(0, 2));
            pop_window = $urandom_range(16, 64);
        end
        pop_window--;
        pop_phase = (pop_phase + 1) % 5;
        case (pop_mode)
            POP_FREE: pop <= rst_n;
            POP_COIN: pop <= rst_n && ($urandom_range(0, 2) != 0);
            default:  pop <= rst_n && (pop_phase < 3);
        endcase
    end

    // Watchdog
    initial begin
        while (cycles < RUN_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        cfg_t       s;
        tick_t      t;
        logic [1:0] levels;
        logic [1:0] raw;
        int         hold_left;
        int         hold_max;
        int         radio_bad;

        levels    = 2'b11;
        hold_left = 0;
        hold_max  = 4;
        radio_bad = 0;
        forecast  = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: first ticks on reset values, the rest on a small setting
        // where debounce, bursts, heartbeat and the stuck timer all act fast.
        for (int i = 0; i < FIRST_TICKS; i++) begin
            send_tick(DIRECTED[i]);
            pace();
        end
        wait_idle();
        write_setting('{16'd1, 8'd2, 16'd2, 32'd4, 32'd3, 32'd10});
        for (int i = FIRST_TICKS; i < 23; i++) begin
            send_tick(DIRECTED[i]);
            pace();
        end
        wait_idle();

        // Random phases. Sensors hold a level for a run of ticks (at times long enough to
        // debounce under small settings) with occasional one-tick chatter; the
        // radio mostly succeeds, with stretches of failures to trip the stuck timer.
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       s = '{16'd0, 8'd255, 16'd0, 32'd0, 32'd0, 32'd0};
                1:       s = '{16'hFFFF, 8'd0, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                               32'hFFFF_FFFF};
                2:       s = '{16'd0, 8'd3, 16'hFFFF, 32'd7, 32'd25, 32'd200};
                default: begin
                    s.debounce_ticks  = 16'($urandom_range(0, 6));
                    s.burst_count     = 8'($urandom_range(0, 5));
                    s.burst_gap_ticks = 16'($urandom_range(0, 8));
                    s.heartbeat_ticks = $urandom_range(1, 30);
                    s.stuck_ticks     = $urandom_range(1, 60);
                    s.settle_ticks    = $urandom_range(0, 600);
                end
            endcase
            write_setting(s);
            hold_max = (s.debounce_ticks > 8) ? 12 : int'(s.debounce_ticks) + 6;
            for (int k = 0; k < RANDOM_TICKS; k++) begin
                if (hold_left == 0) begin
                    levels    = 2'($urandom_range(0, 3));
                    hold_left = $urandom_range(1, hold_max);
                end
                hold_left--;
                raw = levels;
                if ($urandom_range(0, 11) == 0)
                    raw = raw ^ 2'($urandom_range(1, 3));
                if (radio_bad > 0) begin
                    radio_bad--;
                    t.done = 1'($urandom_range(0, 1));
                    t.ok   = 1'b0;
                end else begin
                    if ($urandom_range(0, 29) == 0)
                        radio_bad = $urandom_range(5, 40);
                    t.done = 1'($urandom_range(0, 1));
                    t.ok   = ($urandom_range(0, 3) != 0);
                end
                t.a      = raw[0];
                t.b      = raw[1];
                t.ping   = ($urandom_range(0, 5) == 0);
                t.reboot = ($urandom_range(0, 39) == 0);
                send_tick(t);
                // one mid-phase stop where the sender waits for the block to drain
                if (p == 3 && k == RANDOM_TICKS / 2)
                    wait_idle();
                else
                    pace();
            end
            wait_idle();
        end

        $display("Sent %0d ticks under %0d register settings (reset values included).",
                 ticks_sent, settings_done + 1);
        $display("Checked %0d reports and %0d reset requests.",
                 forecast.reports_seen, forecast.resets_seen);
        if (forecast.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
